// ===== design/oen_pkg.sv =====
// Shared types and constants for the order event normalizer.
// Used by every module of the block; no dependencies of its own.
package oen_pkg;

	localparam logic [3:0] FUNC_ADD     = 4'd0;
	localparam logic [3:0] FUNC_MODIFY  = 4'd1;
	localparam logic [3:0] FUNC_DELETE  = 4'd2;
	localparam logic [3:0] FUNC_EXEC    = 4'd3;
	localparam logic [3:0] FUNC_REPLACE = 4'd4;

	localparam logic [7:0]  SELL_CHAR = 8'h53;
	localparam logic [7:0]  NO_SIDE   = 8'h00;
	localparam logic [63:0] SEQ_RESET = 64'd1;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_MODIFY = 2'd1,
		KIND_DELETE = 2'd2,
		KIND_TRADE  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [3:0]  func;
		logic [31:0] symbol;
		logic [63:0] order_ref;
		logic [63:0] replacement_ref;
		logic [63:0] price_raw;
		logic [31:0] quantity;
		logic [7:0]  side_char;
		logic [63:0] event_time;
	} event_t;

	typedef struct packed {
		logic [63:0] stamp;
		logic [31:0] symbol_out;
		logic [63:0] order_out;
		logic [62:0] price_out;
		logic [31:0] qty_out;
		logic        sell_side;
		kind_t       msg_kind;
		logic        last;
	} msg_t;

	// Decision for the item in the input register.
	typedef struct packed {
		logic emit;       // current half produces a message
		logic final_msg;  // nothing follows from this item
	} chk_t;

	// Handshake between the top level and the input register.
	typedef struct packed {
		logic consume;    // current half leaves the input register
		logic final_msg;  // the item is done after this half
	} adv_t;

endpackage

// ===== design/order_event_normalizer.sv =====
// Channel   Dir  Content
// s_*       in   one parsed event: tuser func, tdata packed event fields
// m_*       out  one normalized message: tuser kind, tlast last of event
// cfg_*     in   initial sequence number (always ready)
//
// One event per cycle enters while the output is not stalled; add, modify, delete
// and execution give one message per cycle. A replace holds the input register for
// its delete message and then its add message. Messages leave from the result register.
// Reset clears both valid flags and loads the sequence counter with 1.
// A stalled output holds its message and backs up into the input register.
module order_event_normalizer (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// symbol[31:0], order_ref[95:32], replacement_ref[159:96],
	// price_raw[223:160], quantity[255:224], side_char[263:256],
	// event_time[327:264]
	input  logic [327:0] s_tdata,
	input  logic [3:0]   s_tuser,   // func[3:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	// wire_seq[63:0], stamp[127:64], symbol_out[159:128], order_out[223:160],
	// price_out[286:224], qty_out[318:287], sell_side[319]
	output logic [319:0] m_tdata,
	output logic [1:0]   m_tuser,   // msg_kind[1:0]
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [63:0]  cfg_data
);

	oen_pkg::event_t ev_in;
	oen_pkg::event_t ev_s1;
	oen_pkg::chk_t   chk;
	oen_pkg::adv_t   adv;
	oen_pkg::msg_t   msg_c;
	oen_pkg::msg_t   msg_q;
	logic            valid_s1;
	logic            phase_s1;
	logic            load_ok;
	logic            load;
	logic [63:0]     seq_out_q;

	assign cfg_ready = 1'b1;

	assign ev_in.func            = s_tuser;
	assign ev_in.symbol          = s_tdata[31:0];
	assign ev_in.order_ref       = s_tdata[95:32];
	assign ev_in.replacement_ref = s_tdata[159:96];
	assign ev_in.price_raw       = s_tdata[223:160];
	assign ev_in.quantity        = s_tdata[255:224];
	assign ev_in.side_char       = s_tdata[263:256];
	assign ev_in.event_time      = s_tdata[327:264];

	oen_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.ev_in    (ev_in),
		.adv      (adv),
		.s_tready (s_tready),
		.valid_s1 (valid_s1),
		.phase_s1 (phase_s1),
		.ev_s1    (ev_s1)
	);

	oen_check u_check (
		.ev    (ev_s1),
		.phase (phase_s1),
		.chk   (chk),
		.msg   (msg_c)
	);

	// drop rejected events without waiting on the output
	assign adv.consume   = valid_s1 && (!chk.emit || load_ok);
	assign adv.final_msg = chk.final_msg;
	assign load          = valid_s1 && chk.emit && load_ok;

	oen_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.load      (load),
		.msg_in    (msg_c),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.load_ok   (load_ok),
		.seq_out_q (seq_out_q),
		.msg_q     (msg_q)
	);

	assign m_tdata = {msg_q.sell_side, msg_q.qty_out, msg_q.price_out, msg_q.order_out,
		msg_q.symbol_out, msg_q.stamp, seq_out_q};
	assign m_tuser = msg_q.msg_kind;
	assign m_tlast = msg_q.last;

`ifndef NO_ASSERTIONS
	a_phase_replace: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && phase_s1 |-> ev_s1.func == oen_pkg::FUNC_REPLACE)
		else $error("second half held for a non-replace event");

	a_phase_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_s1 |-> valid_s1 && !chk.final_msg == 1'b0 && chk.emit)
		else $error("replace add half lost");

	a_notlast_delete: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser == oen_pkg::KIND_DELETE)
		else $error("non-final message is not a delete");

	a_seq_step: assert property (@(posedge clk) disable iff (!arst_n)
		load && !cfg_valid |=> seq_out_q + 64'd1 == u_out.seq_q)
		else $error("sequence did not advance by one");
`endif

endmodule

// ===== design/oen_in_stage.sv =====
// Input register of the normalizer: holds one event and its replace phase.
// Depends on oen_pkg.
module oen_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  oen_pkg::event_t ev_in,
	input  oen_pkg::adv_t   adv,
	output logic            s_tready,
	output logic            valid_s1,
	output logic            phase_s1,
	output oen_pkg::event_t ev_s1
);

	logic accept;

	assign s_tready = !valid_s1 || (adv.consume && adv.final_msg);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_s1 <= 1'b0;
		end else if (adv.consume && !adv.final_msg) begin
			// first half of a replace went out; hold the event for the add
			phase_s1 <= 1'b1;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
			phase_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ev_s1 <= ev_in;
		end
	end

endmodule

// ===== design/oen_check.sv =====
// Rule check and message build for one event half.
// Depends on oen_pkg; purely combinational.
module oen_check (
	input  oen_pkg::event_t ev,
	input  logic            phase,
	output oen_pkg::chk_t   chk,
	output oen_pkg::msg_t   msg
);

	logic        price_ok;
	logic        qty_ok;
	logic        side_ok;
	logic        sym_ok;
	logic [62:0] price;

	assign price_ok = !ev.price_raw[63];
	assign qty_ok   = (ev.quantity != 32'd0);
	assign side_ok  = (ev.side_char != oen_pkg::NO_SIDE);
	assign sym_ok   = (ev.symbol != 32'd0);
	assign price    = price_ok ? ev.price_raw[62:0] : 63'd0;

	always_comb begin
		chk.emit       = 1'b0;
		chk.final_msg  = 1'b1;
		msg.stamp      = ev.event_time;
		msg.symbol_out = ev.symbol;
		msg.order_out  = ev.order_ref;
		msg.price_out  = price;
		msg.qty_out    = ev.quantity;
		msg.sell_side  = (ev.side_char == oen_pkg::SELL_CHAR);
		msg.msg_kind   = oen_pkg::KIND_ADD;
		msg.last       = 1'b1;
		case (ev.func)
			oen_pkg::FUNC_ADD: begin
				chk.emit = sym_ok && price_ok && qty_ok && side_ok;
			end
			oen_pkg::FUNC_MODIFY: begin
				chk.emit     = sym_ok && price_ok && side_ok;
				msg.msg_kind = oen_pkg::KIND_MODIFY;
			end
			oen_pkg::FUNC_DELETE: begin
				chk.emit      = sym_ok;
				msg.price_out = 63'd0;
				msg.qty_out   = 32'd0;
				msg.msg_kind  = oen_pkg::KIND_DELETE;
			end
			oen_pkg::FUNC_EXEC: begin
				chk.emit     = sym_ok && qty_ok;
				msg.msg_kind = oen_pkg::KIND_TRADE;
			end
			oen_pkg::FUNC_REPLACE: begin
				if (phase) begin
					// second half: add under the new id
					chk.emit      = 1'b1;
					msg.order_out = ev.replacement_ref;
				end else begin
					chk.emit = sym_ok && price_ok && qty_ok && side_ok
						&& (ev.replacement_ref != 64'd0);
					chk.final_msg = !chk.emit;
					msg.price_out = 63'd0;
					msg.qty_out   = 32'd0;
					msg.msg_kind  = oen_pkg::KIND_DELETE;
					msg.last      = 1'b0;
				end
			end
			default: begin
				chk.emit = 1'b0;
			end
		endcase
	end

endmodule

// ===== design/oen_out_stage.sv =====
// Result register and wrapping sequence counter.
// Depends on oen_pkg.
module oen_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	input  logic [63:0]   cfg_data,
	input  logic          load,
	input  oen_pkg::msg_t msg_in,
	input  logic          m_tready,
	output logic          m_tvalid,
	output logic          load_ok,
	output logic [63:0]   seq_out_q,
	output oen_pkg::msg_t msg_q
);

	logic [63:0] seq_q;

	assign load_ok = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q    <= oen_pkg::SEQ_RESET;
			m_tvalid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				seq_q <= cfg_data;
			end else if (load) begin
				seq_q <= seq_q + 64'd1;
			end
			if (load_ok) begin
				m_tvalid <= load;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			msg_q     <= msg_in;
			seq_out_q <= seq_q;
		end
	end

endmodule
